>>> rtl/core/ccc_pkg.sv
// Shared types and constants for the console cursor controller.
// No dependencies; every other file of the block refers to this package by scoped names.
package ccc_pkg;

  // Default console count for the top-level parameter.
  localparam int CONSOLES_DEF = 4;
  // Column step of a tab.
  localparam int TAB_STEP = 8;

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_LEFT_MARGIN   = 3'd0;
  localparam logic [2:0] REG_RIGHT_MARGIN  = 3'd1;
  localparam logic [2:0] REG_TOP_MARGIN    = 3'd2;
  localparam logic [2:0] REG_BOTTOM_MARGIN = 3'd3;
  localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd4;
  localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_TERMINAL_MODE = 3'd6;
  localparam logic [2:0] REG_VERBOSE_MODE  = 3'd7;

  // Register reset values.
  localparam logic [7:0] LEFT_MARGIN_RST   = 8'd0;
  localparam logic [7:0] RIGHT_MARGIN_RST  = 8'd80;
  localparam logic [7:0] TOP_MARGIN_RST    = 8'd0;
  localparam logic [7:0] BOTTOM_MARGIN_RST = 8'd25;
  localparam logic [5:0] GLYPH_WIDTH_RST   = 6'd8;
  localparam logic [5:0] GLYPH_HEIGHT_RST  = 6'd8;

  // Character codes with special meaning.
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Result kinds.
  localparam logic KIND_SCROLL = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  // Largest pixel coordinate; larger products saturate here.
  localparam logic [12:0] PIXEL_MAX = 13'd8191;

  typedef struct packed {
    logic [7:0]  left_margin;
    logic [7:0]  right_margin;
    logic [7:0]  top_margin;
    logic [7:0]  bottom_margin;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic        terminal_mode;
    logic        verbose_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [1:0]  console_index;
    logic [31:0] fg_color;
  } char_item_t;

  typedef struct packed {
    logic        kind;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [7:0]  glyph;
    logic        opaque;
    logic [31:0] draw_color;
    logic [1:0]  target_console;
    logic        last;
  } result_t;

  // One classified character as handed from the front to the back.
  typedef struct packed {
    logic        scroll;
    logic        draw;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [7:0]  glyph;
    logic        opaque;
    logic [31:0] color;
    logic [1:0]  console;
  } cmd_t;

endpackage

>>> rtl/core/ccc_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on ccc_pkg for the register map, reset values and cfg_t.
module ccc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccc_pkg::ADDR_W-1:0] paddr,
  input  logic [ccc_pkg::DATA_W-1:0] pwdata,
  output logic [ccc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ccc_pkg::cfg_t              cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_margin   <= ccc_pkg::LEFT_MARGIN_RST;
      cfg.right_margin  <= ccc_pkg::RIGHT_MARGIN_RST;
      cfg.top_margin    <= ccc_pkg::TOP_MARGIN_RST;
      cfg.bottom_margin <= ccc_pkg::BOTTOM_MARGIN_RST;
      cfg.glyph_width   <= ccc_pkg::GLYPH_WIDTH_RST;
      cfg.glyph_height  <= ccc_pkg::GLYPH_HEIGHT_RST;
      cfg.terminal_mode <= 1'b0;
      cfg.verbose_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        ccc_pkg::REG_LEFT_MARGIN:   cfg.left_margin   <= pwdata[7:0];
        ccc_pkg::REG_RIGHT_MARGIN:  cfg.right_margin  <= pwdata[7:0];
        ccc_pkg::REG_TOP_MARGIN:    cfg.top_margin    <= pwdata[7:0];
        ccc_pkg::REG_BOTTOM_MARGIN: cfg.bottom_margin <= pwdata[7:0];
        ccc_pkg::REG_GLYPH_WIDTH:   cfg.glyph_width   <= pwdata[5:0];
        ccc_pkg::REG_GLYPH_HEIGHT:  cfg.glyph_height  <= pwdata[5:0];
        ccc_pkg::REG_TERMINAL_MODE: cfg.terminal_mode <= pwdata[0];
        ccc_pkg::REG_VERBOSE_MODE:  cfg.verbose_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      ccc_pkg::REG_LEFT_MARGIN:   prdata = 32'(cfg.left_margin);
      ccc_pkg::REG_RIGHT_MARGIN:  prdata = 32'(cfg.right_margin);
      ccc_pkg::REG_TOP_MARGIN:    prdata = 32'(cfg.top_margin);
      ccc_pkg::REG_BOTTOM_MARGIN: prdata = 32'(cfg.bottom_margin);
      ccc_pkg::REG_GLYPH_WIDTH:   prdata = 32'(cfg.glyph_width);
      ccc_pkg::REG_GLYPH_HEIGHT:  prdata = 32'(cfg.glyph_height);
      ccc_pkg::REG_TERMINAL_MODE: prdata = 32'(cfg.terminal_mode);
      ccc_pkg::REG_VERBOSE_MODE:  prdata = 32'(cfg.verbose_mode);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/ccc_front.sv
// Front part: accepts characters, keeps the per-console cursors and the last
// character, and queues a command for every character that yields results. Uses ccc_pkg.
module ccc_front #(
  parameter int CONSOLES = ccc_pkg::CONSOLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ccc_pkg::cfg_t       cfg,
  input  logic                push,
  input  ccc_pkg::char_item_t char_item,
  input  logic                queue_full,
  output logic                cmd_push,
  output ccc_pkg::cmd_t       cmd
);

  localparam int IDX_W = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

  logic [7:0] cursor_col [CONSOLES];
  logic [7:0] cursor_row [CONSOLES];
  logic [7:0] previous_char;

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             accept;
  logic [7:0]       cur_x;
  logic [7:0]       cur_y;
  logic [7:0]       col_next;
  logic [7:0]       row_next;
  logic [7:0]       right_lim;
  logic [7:0]       bottom_lim;
  logic [8:0]       tab_sum;
  logic             scroll;
  logic             draw;
  logic [7:0]       c;

  assign c        = char_item.char_code;
  assign idx      = IDX_W'(char_item.console_index);
  assign in_range = 32'(char_item.console_index) < CONSOLES;
  assign accept   = push && !queue_full && in_range;
  assign cur_x    = cursor_col[idx];
  assign cur_y    = cursor_row[idx];

  assign right_lim  = (cfg.right_margin == 8'd0) ? 8'd0 : cfg.right_margin - 8'd1;
  assign bottom_lim = (cfg.bottom_margin == 8'd0) ? 8'd0 : cfg.bottom_margin - 8'd1;
  assign tab_sum    = {1'b0, cur_x} + 9'(ccc_pkg::TAB_STEP);

  always_comb begin
    col_next = cur_x;
    row_next = cur_y;
    scroll   = 1'b0;
    draw     = 1'b0;
    priority if (c == ccc_pkg::CH_FF) begin
      col_next = cfg.left_margin;
      row_next = cfg.top_margin;
    end else if (c == ccc_pkg::CH_LF) begin
      if (cur_y >= bottom_lim) begin
        scroll   = 1'b1;
        col_next = cfg.left_margin;
        row_next = bottom_lim;
      end else begin
        row_next = cur_y + 8'd1;
        if (previous_char == ccc_pkg::CH_CR || cfg.terminal_mode || cfg.verbose_mode) begin
          col_next = cfg.left_margin;
        end
      end
    end else if (c == ccc_pkg::CH_TAB) begin
      col_next = tab_sum[8] ? 8'd255 : tab_sum[7:0];
    end else if (c == ccc_pkg::CH_CR) begin
      col_next = cfg.left_margin;
    end else if (c == ccc_pkg::CH_BS) begin
      col_next = (cur_x > cfg.left_margin) ? cur_x - 8'd1 : cfg.left_margin;
    end else begin
      draw = 1'b1;
      // Wrap to the next line at the right margin; the row stops at 255.
      if (cur_x >= right_lim) begin
        col_next = cfg.left_margin;
        row_next = (cur_y == 8'd255) ? cur_y : cur_y + 8'd1;
      end else begin
        col_next = cur_x + 8'd1;
      end
      if (row_next >= cfg.bottom_margin) begin
        scroll   = 1'b1;
        col_next = cfg.left_margin;
        row_next = bottom_lim;
      end
    end
  end

  assign cmd_push    = accept && (scroll || draw);
  assign cmd.scroll  = scroll;
  assign cmd.draw    = draw;
  assign cmd.col     = col_next;
  assign cmd.row     = row_next;
  assign cmd.glyph   = c;
  assign cmd.opaque  = cfg.terminal_mode;
  assign cmd.color   = cfg.terminal_mode ? 32'd0 : char_item.fg_color;
  assign cmd.console = char_item.console_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONSOLES; i++) begin
        cursor_col[i] <= '0;
        cursor_row[i] <= '0;
      end
      previous_char <= '0;
    end else if (accept) begin
      cursor_col[idx] <= col_next;
      cursor_row[idx] <= row_next;
      if (c != ccc_pkg::CH_FF) begin
        previous_char <= c;
      end
    end
  end

endmodule

>>> rtl/core/ccc_cmd_queue.sv
// Short command queue between the front and back parts.
// Depends on ccc_pkg for cmd_t and the queue depth.
module ccc_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ccc_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output ccc_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);

  ccc_pkg::cmd_t                   slots [ccc_pkg::QUEUE_DEPTH];
  logic [ccc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [ccc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [ccc_pkg::QUEUE_PTR_W:0]   count;

  assign full    = count == (ccc_pkg::QUEUE_PTR_W + 1)'(ccc_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/ccc_back.sv
// Back part: turns queued commands into scroll and draw results, scaling the
// cursor to pixels, and holds the result on the output register. Uses ccc_pkg.
module ccc_back (
  input  logic             clk,
  input  logic             rst,
  input  ccc_pkg::cfg_t    cfg,
  input  logic             queue_empty,
  input  ccc_pkg::cmd_t    queue_data,
  output logic             queue_pop,
  output logic             empty,
  input  logic             pop,
  output ccc_pkg::result_t result
);

  typedef struct packed {
    logic        scroll;
    logic        draw;
    logic [12:0] px;
    logic [12:0] py;
    logic [7:0]  glyph;
    logic        opaque;
    logic [31:0] color;
    logic [1:0]  console;
  } stage_t;

  stage_t           stage;
  logic             stage_valid;
  logic             out_valid;
  ccc_pkg::result_t res_next;
  logic             out_load;
  logic             stage_emit;
  logic             stage_done;
  logic             stage_free;
  logic [13:0]      prod_x;
  logic [13:0]      prod_y;

  assign prod_x = 14'(queue_data.col) * 14'(cfg.glyph_width);
  assign prod_y = 14'(queue_data.row) * 14'(cfg.glyph_height);

  assign out_load   = !out_valid || pop;
  assign stage_emit = stage_valid && out_load;
  // A pending scroll goes out first; the draw, if any, follows it from the same stage.
  assign stage_done = !stage.scroll || !stage.draw;
  assign stage_free = !stage_valid || (stage_emit && stage_done);
  assign queue_pop  = !queue_empty && stage_free;
  assign empty      = !out_valid;

  always_comb begin
    res_next.target_console = stage.console;
    if (stage.scroll) begin
      res_next.kind       = ccc_pkg::KIND_SCROLL;
      res_next.pixel_x    = '0;
      res_next.pixel_y    = '0;
      res_next.glyph      = '0;
      res_next.opaque     = 1'b0;
      res_next.draw_color = '0;
      res_next.last       = !stage.draw;
    end else begin
      res_next.kind       = ccc_pkg::KIND_DRAW;
      res_next.pixel_x    = stage.px;
      res_next.pixel_y    = stage.py;
      res_next.glyph      = stage.glyph;
      res_next.opaque     = stage.opaque;
      res_next.draw_color = stage.color;
      res_next.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (queue_pop) begin
        stage_valid <= 1'b1;
      end else if (stage_free) begin
        stage_valid <= 1'b0;
      end
      if (stage_emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (queue_pop) begin
      stage.scroll  <= queue_data.scroll;
      stage.draw    <= queue_data.draw;
      stage.px      <= prod_x[13] ? ccc_pkg::PIXEL_MAX : prod_x[12:0];
      stage.py      <= prod_y[13] ? ccc_pkg::PIXEL_MAX : prod_y[12:0];
      stage.glyph   <= queue_data.glyph;
      stage.opaque  <= queue_data.opaque;
      stage.color   <= queue_data.color;
      stage.console <= queue_data.console;
    end else if (stage_emit) begin
      stage.scroll <= 1'b0;
    end
    if (stage_emit) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/core/console_cursor_controller.sv
// Top level of the console cursor controller: register file, front, command queue and back.
// Depends on ccc_pkg, ccc_regs, ccc_front, ccc_cmd_queue and ccc_back.
//
// A character is accepted every cycle while full is low; full rises only when
// the four-entry command queue is full. Cursor updates are done in the cycle
// of acceptance, so characters that move the cursor without output add nothing
// to the queue, although they too wait while full is high. Characters that
// yield output pass through the queue, a pixel scaling stage and the output
// register. The back part delivers one result per cycle while pop is held, so a
// printable character yields one result, or two when it scrolls. Configuration
// is to be written only while the block is idle.
module console_cursor_controller #(
  parameter int CONSOLES = ccc_pkg::CONSOLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  ccc_pkg::char_item_t        char_item,
  output logic                       empty,
  input  logic                       pop,
  output ccc_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccc_pkg::ADDR_W-1:0] paddr,
  input  logic [ccc_pkg::DATA_W-1:0] pwdata,
  output logic [ccc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  ccc_pkg::cfg_t cfg;
  ccc_pkg::cmd_t cmd;
  ccc_pkg::cmd_t queue_data;
  logic          cmd_push;
  logic          queue_full;
  logic          queue_empty;
  logic          queue_pop;

  assign full = queue_full;

  ccc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccc_front #(
    .CONSOLES (CONSOLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .char_item  (char_item),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  ccc_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .rd_en   (queue_pop),
    .rd_data (queue_data),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  ccc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .queue_data  (queue_data),
    .queue_pop   (queue_pop),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

>>> test/console_cursor_controller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for console_cursor_controller: feeds character transactions on the
// push/full side and checks every scroll and draw command on the pop/empty side.
// Depends on ccc_pkg and the console_cursor_controller RTL.
module console_cursor_controller_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 5;
  localparam int CHARS_PER_PHASE = 250;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  ccc_pkg::char_item_t char_item = '0;
  logic empty;
  logic pop = 1'b0;
  ccc_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ccc_pkg::ADDR_W-1:0] paddr = '0;
  logic [ccc_pkg::DATA_W-1:0] pwdata = '0;
  logic [ccc_pkg::DATA_W-1:0] prdata;
  logic pready;

  // Predicted state of the block.
  ccc_pkg::cfg_t shadow_cfg;
  logic [7:0] col_of [ccc_pkg::CONSOLES_DEF];
  logic [7:0] row_of [ccc_pkg::CONSOLES_DEF];
  logic [7:0] last_char;
  ccc_pkg::result_t pending_commands[$];

  int error_count = 0;
  int idle_cycles = 0;
  int hold_request = 0;
  bit steady = 1'b0;

  console_cursor_controller DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_item(char_item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(99));
    if (r < 80) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic int less_one(int v);
    return (v == 0) ? 0 : v - 1;
  endfunction

  function automatic logic [12:0] scale_to_pixels(int size, int pos);
    int p;
    p = size * pos;
    return (p > int'(ccc_pkg::PIXEL_MAX)) ? ccc_pkg::PIXEL_MAX : p[12:0];
  endfunction

  function automatic ccc_pkg::result_t scroll_command(logic [1:0] con, logic is_last);
    ccc_pkg::result_t r;
    r = '0;
    r.kind = ccc_pkg::KIND_SCROLL;
    r.target_console = con;
    r.last = is_last;
    return r;
  endfunction

  // Moves the predicted cursor for one accepted character and queues its commands.
  task automatic track_cursor(ccc_pkg::char_item_t chr);
    logic [7:0] c;
    logic [1:0] con;
    int x, y, lim, left;
    ccc_pkg::result_t r;
    c = chr.char_code;
    con = chr.console_index;
    x = int'(col_of[con]);
    y = int'(row_of[con]);
    left = int'(shadow_cfg.left_margin);
    if (c == ccc_pkg::CH_FF) begin
      row_of[con] = shadow_cfg.top_margin;
      col_of[con] = shadow_cfg.left_margin;
      return;
    end
    if (c == ccc_pkg::CH_LF) begin
      lim = less_one(int'(shadow_cfg.bottom_margin));
      if (y >= lim) begin
        x = left;
        y = lim;
        pending_commands.push_back(scroll_command(con, 1'b1));
      end else begin
        y++;
        if (last_char == ccc_pkg::CH_CR || shadow_cfg.terminal_mode ||
            shadow_cfg.verbose_mode) begin
          x = left;
        end
      end
    end else if (c == ccc_pkg::CH_TAB) begin
      x = (x + ccc_pkg::TAB_STEP > 255) ? 255 : x + ccc_pkg::TAB_STEP;
    end else if (c == ccc_pkg::CH_CR) begin
      x = left;
    end else if (c == ccc_pkg::CH_BS) begin
      x = (x > left) ? x - 1 : left;
    end else begin
      if (x >= less_one(int'(shadow_cfg.right_margin))) begin
        x = left;
        if (y < 255) y++;
      end else begin
        x++;
      end
      if (y >= int'(shadow_cfg.bottom_margin)) begin
        x = left;
        y = less_one(int'(shadow_cfg.bottom_margin));
        pending_commands.push_back(scroll_command(con, 1'b0));
      end
      r = '0;
      r.kind = ccc_pkg::KIND_DRAW;
      r.pixel_x = scale_to_pixels(int'(shadow_cfg.glyph_width), x);
      r.pixel_y = scale_to_pixels(int'(shadow_cfg.glyph_height), y);
      r.glyph = c;
      r.opaque = shadow_cfg.terminal_mode;
      r.draw_color = shadow_cfg.terminal_mode ? 32'd0 : chr.fg_color;
      r.target_console = con;
      r.last = 1'b1;
      pending_commands.push_back(r);
    end
    col_of[con] = x[7:0];
    row_of[con] = y[7:0];
    last_char = c;
  endtask

  task automatic send_char(logic [7:0] code, logic [1:0] con, logic [31:0] color);
    int gap;
    ccc_pkg::char_item_t chr;
    chr.char_code = code;
    chr.console_index = con;
    chr.fg_color = color;
    gap = (!steady && $urandom_range(99) < 25) ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    char_item <= chr;
    do @(posedge clk); while (full);
    track_cursor(chr);
  endtask

  // Stops input and waits until every predicted command has been popped.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= ccc_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      ccc_pkg::REG_LEFT_MARGIN: shadow_cfg.left_margin = value;
      ccc_pkg::REG_RIGHT_MARGIN: shadow_cfg.right_margin = value;
      ccc_pkg::REG_TOP_MARGIN: shadow_cfg.top_margin = value;
      ccc_pkg::REG_BOTTOM_MARGIN: shadow_cfg.bottom_margin = value;
      ccc_pkg::REG_GLYPH_WIDTH: shadow_cfg.glyph_width = value[5:0];
      ccc_pkg::REG_GLYPH_HEIGHT: shadow_cfg.glyph_height = value[5:0];
      ccc_pkg::REG_TERMINAL_MODE: shadow_cfg.terminal_mode = value[0];
      ccc_pkg::REG_VERBOSE_MODE: shadow_cfg.verbose_mode = value[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(ccc_pkg::cfg_t c);
    wait_idle();
    write_register(ccc_pkg::REG_LEFT_MARGIN, c.left_margin);
    write_register(ccc_pkg::REG_RIGHT_MARGIN, c.right_margin);
    write_register(ccc_pkg::REG_TOP_MARGIN, c.top_margin);
    write_register(ccc_pkg::REG_BOTTOM_MARGIN, c.bottom_margin);
    write_register(ccc_pkg::REG_GLYPH_WIDTH, {2'b00, c.glyph_width});
    write_register(ccc_pkg::REG_GLYPH_HEIGHT, {2'b00, c.glyph_height});
    write_register(ccc_pkg::REG_TERMINAL_MODE, {7'd0, c.terminal_mode});
    write_register(ccc_pkg::REG_VERBOSE_MODE, {7'd0, c.verbose_mode});
  endtask

  task automatic send_random_text(int count);
    int sent, pick;
    logic [1:0] con;
    sent = 0;
    while (sent < count) begin
      pick = int'($urandom_range(99));
      con = 2'($urandom_range(0, 3));
      if (pick < 50) begin
        send_char(8'($urandom_range(32, 126)), con, $urandom);
      end else if (pick < 58) begin
        send_char(ccc_pkg::CH_LF, con, $urandom);
      end else if (pick < 64) begin
        // Line break written as CR then LF, so LF sees a preceding CR.
        send_char(ccc_pkg::CH_CR, con, $urandom);
        send_char(ccc_pkg::CH_LF, con, $urandom);
        sent++;
      end else if (pick < 68) begin
        send_char(ccc_pkg::CH_CR, con, $urandom);
      end else if (pick < 72) begin
        send_char(ccc_pkg::CH_TAB, con, $urandom);
      end else if (pick < 77) begin
        send_char(ccc_pkg::CH_BS, con, $urandom);
      end else if (pick < 80) begin
        send_char(ccc_pkg::CH_FF, con, $urandom);
      end else begin
        send_char(8'($urandom_range(0, 255)), con, $urandom);
      end
      sent++;
    end
  endtask

  task automatic test_control_codes();
    send_char("A", 2'd0, 32'h0000_0000);
    send_char(8'hFF, 2'd1, 32'hFFFF_FFFF);
    send_char(8'h00, 2'd3, 32'hA5A5_5A5A);
    send_char(ccc_pkg::CH_CR, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_LF, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_TAB, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_BS, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_BS, 2'd2, 32'h0);
    send_char(ccc_pkg::CH_FF, 2'd1, 32'h0);
    send_char(ccc_pkg::CH_LF, 2'd1, 32'h5A5A_A5A5);
  endtask

  // Margins at or near the top of their range, huge glyphs and opaque drawing.
  task automatic test_margin_extremes();
    ccc_pkg::cfg_t c;
    c.left_margin = 8'd250;
    c.right_margin = 8'd255;
    c.top_margin = 8'd255;
    c.bottom_margin = 8'd255;
    c.glyph_width = 6'd63;
    c.glyph_height = 6'd63;
    c.terminal_mode = 1'b1;
    c.verbose_mode = 1'b0;
    apply_settings(c);
    send_char(ccc_pkg::CH_FF, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_TAB, 2'd0, 32'h0);
    send_char("x", 2'd0, 32'h1234_5678);
    send_char(ccc_pkg::CH_BS, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_LF, 2'd0, 32'h0);
    send_char(ccc_pkg::CH_LF, 2'd2, 32'h0);
    send_char("z", 2'd2, 32'hFFFF_FFFF);
  endtask

  // Zero margins and zero glyph sizes: every character wraps and scrolls at pixel 0.
  task automatic test_zero_margins();
    ccc_pkg::cfg_t c;
    c = '0;
    c.verbose_mode = 1'b1;
    apply_settings(c);
    send_char("a", 2'd0, 32'hDEAD_BEEF);
    send_char(ccc_pkg::CH_LF, 2'd1, 32'h0);
    send_char("b", 2'd3, 32'h0F0F_0F0F);
    send_char(ccc_pkg::CH_LF, 2'd2, 32'h0);
  endtask

  task automatic test_random_text();
    ccc_pkg::cfg_t c;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      c.left_margin = 8'($urandom_range(0, 12));
      c.right_margin = c.left_margin + 8'($urandom_range(0, 40));
      c.top_margin = 8'($urandom_range(0, 6));
      c.bottom_margin = 8'($urandom_range(1, 10));
      if ($urandom_range(3) == 0) begin
        c.left_margin = 8'($urandom_range(0, 255));
        c.right_margin = 8'($urandom_range(0, 255));
        c.top_margin = 8'($urandom_range(0, 255));
        c.bottom_margin = 8'($urandom_range(0, 255));
      end
      c.glyph_width = 6'($urandom_range(0, 63));
      c.glyph_height = 6'($urandom_range(0, 63));
      c.terminal_mode = 1'($urandom_range(0, 1));
      c.verbose_mode = 1'($urandom_range(0, 1));
      apply_settings(c);
      steady = (phase == 2);
      send_random_text(CHARS_PER_PHASE);
      steady = 1'b0;
    end
  endtask

  // The receiver holds off while printable characters keep coming until full rises.
  task automatic test_full_queue();
    wait_idle();
    steady = 1'b1;
    hold_request = HOLD_OFF_CYCLES;
    @(posedge clk);
    for (int i = 0; i < 60; i++) begin
      send_char(8'($urandom_range(32, 126)), 2'($urandom_range(0, 3)), $urandom);
    end
    steady = 1'b0;
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (steady) begin
        pop <= 1'b1;
      end else if ($urandom_range(99) < 10) begin
        stall_left = pick_gap();
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ccc_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (pending_commands.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
        error_count++;
      end else begin
        want = pending_commands.pop_front();
        check_field("kind", 32'(want.kind), 32'(result.kind));
        check_field("pixel_x", 32'(want.pixel_x), 32'(result.pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(result.pixel_y));
        check_field("glyph", 32'(want.glyph), 32'(result.glyph));
        check_field("opaque", 32'(want.opaque), 32'(result.opaque));
        check_field("draw_color", want.draw_color, result.draw_color);
        check_field("target_console", 32'(want.target_console),
                    32'(result.target_console));
        check_field("last", 32'(want.last), 32'(result.last));
      end
    end
  end

  // Ends the run when no transaction of any kind has happened for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout, %0d commands outstanding", $time,
               pending_commands.size());
      $display("console_cursor_controller_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    shadow_cfg.left_margin = ccc_pkg::LEFT_MARGIN_RST;
    shadow_cfg.right_margin = ccc_pkg::RIGHT_MARGIN_RST;
    shadow_cfg.top_margin = ccc_pkg::TOP_MARGIN_RST;
    shadow_cfg.bottom_margin = ccc_pkg::BOTTOM_MARGIN_RST;
    shadow_cfg.glyph_width = ccc_pkg::GLYPH_WIDTH_RST;
    shadow_cfg.glyph_height = ccc_pkg::GLYPH_HEIGHT_RST;
    shadow_cfg.terminal_mode = 1'b0;
    shadow_cfg.verbose_mode = 1'b0;
    for (int i = 0; i < ccc_pkg::CONSOLES_DEF; i++) begin
      col_of[i] = 8'd0;
      row_of[i] = 8'd0;
    end
    last_char = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_control_codes();
    test_margin_extremes();
    test_zero_margins();
    test_random_text();
    test_full_queue();
    push <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("console_cursor_controller_test: PASS");
    end else begin
      $display("console_cursor_controller_test: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ccc_pkg.sv
rtl/core/ccc_regs.sv
rtl/core/ccc_front.sv
rtl/core/ccc_cmd_queue.sv
rtl/core/ccc_back.sv
rtl/core/console_cursor_controller.sv
test/console_cursor_controller_test.sv
